// ----- rtl/rrac_pkg.sv -----
// Shared constants, codes and structures for the region range access check.
// Used by every module of the block; depends on nothing.
package rrac_pkg;

   localparam int REGION_COUNT = 16;
   localparam int ADDR_BITS    = 32;
   localparam int PERM_BITS    = 4;
   localparam int INDEX_BITS   = 4;
   localparam int LEN_BITS     = 33;
   localparam int TBL_IDX_BITS = $clog2(REGION_COUNT);
   localparam int STEP_BITS    = $clog2(REGION_COUNT + 1);

   localparam logic [1:0] MODE_WRITE   = 2'd0;
   localparam logic [1:0] MODE_CHECK   = 2'd1;
   localparam logic [1:0] MODE_MEASURE = 2'd2;

   typedef struct packed {
      logic                    en;
      logic [TBL_IDX_BITS-1:0] index;
      logic [ADDR_BITS-1:0]    first;
      logic [ADDR_BITS-1:0]    last;
      logic [PERM_BITS-1:0]    perm;
      logic                    valid;
   } wr_type;

   typedef struct packed {
      logic                 hit;
      logic [ADDR_BITS-1:0] last;
      logic [PERM_BITS-1:0] perm;
   } match_type;

   typedef struct packed {
      logic                 start;
      logic [1:0]           mode;
      logic [ADDR_BITS-1:0] addr;
      logic [LEN_BITS-1:0]  len;
      logic [PERM_BITS-1:0] perm;
   } cmd_type;

endpackage

// ----- rtl/rrac_table.sv -----
// Region table: entry registers with one write port and a parallel address match.
// Depends on rrac_pkg for widths and the write and match structures.
module rrac_table (
   input  logic                           clock,
   input  logic                           reset,
   input  rrac_pkg::wr_type               wr,
   input  logic [rrac_pkg::ADDR_BITS:0]   pos,
   output rrac_pkg::match_type            match
);

   logic [rrac_pkg::REGION_COUNT-1:0] valid_ff;
   logic [rrac_pkg::ADDR_BITS-1:0]    first_ff [rrac_pkg::REGION_COUNT];
   logic [rrac_pkg::ADDR_BITS-1:0]    last_ff  [rrac_pkg::REGION_COUNT];
   logic [rrac_pkg::PERM_BITS-1:0]    perm_ff  [rrac_pkg::REGION_COUNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.index] <= wr.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         first_ff[wr.index] <= wr.first;
         last_ff[wr.index]  <= wr.last;
         perm_ff[wr.index]  <= wr.perm;
      end
   end

   // The lowest matching index is applied last, so it wins.
   always_comb begin
      match = '0;
      for (int i = rrac_pkg::REGION_COUNT - 1; i >= 0; i--) begin
         if (valid_ff[i] && !pos[rrac_pkg::ADDR_BITS] &&
             first_ff[i] <= pos[rrac_pkg::ADDR_BITS-1:0] &&
             last_ff[i] >= pos[rrac_pkg::ADDR_BITS-1:0]) begin
            match.hit  = 1'b1;
            match.last = last_ff[i];
            match.perm = perm_ff[i];
         end
      end
   end

endmodule

// ----- rtl/rrac_walk.sv -----
// Walk sequencer: steps a position through the region table one region per cycle
// and holds the result register. Depends on rrac_pkg and drives rrac_table's lookup.
module rrac_walk (
   input  logic                           clock,
   input  logic                           reset,
   input  rrac_pkg::cmd_type              cmd,
   output logic                           busy,
   output logic [rrac_pkg::ADDR_BITS:0]   pos,
   input  rrac_pkg::match_type            match,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_accessible,
   output logic [rrac_pkg::LEN_BITS-1:0]  rsp_range_bytes
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STEP,
      ST_FIN,
      ST_RESP
   } state_type;

   state_type                          state_ff;
   logic [1:0]                         kind_ff;
   logic [rrac_pkg::ADDR_BITS:0]       pos_ff;
   logic [rrac_pkg::ADDR_BITS+1:0]     stop_ff;
   logic [rrac_pkg::ADDR_BITS-1:0]     addr_ff;
   logic [rrac_pkg::PERM_BITS-1:0]     perm_ff;
   logic [rrac_pkg::STEP_BITS-1:0]     step_ff;
   logic                               rsp_valid_ff;
   logic                               accessible_ff;
   logic [rrac_pkg::LEN_BITS-1:0]      bytes_ff;
   logic [rrac_pkg::ADDR_BITS+1:0]     stop_in;
   logic                               past_stop;
   logic                               perm_ok;

   always_comb begin
      if (cmd.len == '0) begin
         stop_in = (rrac_pkg::ADDR_BITS + 2)'(cmd.addr);
      end else begin
         stop_in = (rrac_pkg::ADDR_BITS + 2)'(cmd.addr) +
                   (rrac_pkg::ADDR_BITS + 2)'(cmd.len) - (rrac_pkg::ADDR_BITS + 2)'(1);
      end
   end

   assign past_stop = {1'b0, pos_ff} > stop_ff;
   assign perm_ok   = (match.perm & perm_ff) == perm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd.start) begin
                  kind_ff <= cmd.mode;
                  pos_ff  <= {1'b0, cmd.addr};
                  addr_ff <= cmd.addr;
                  stop_ff <= stop_in;
                  perm_ff <= cmd.perm;
                  step_ff <= '0;
                  if (cmd.mode == rrac_pkg::MODE_CHECK ||
                      cmd.mode == rrac_pkg::MODE_MEASURE) begin
                     state_ff <= ST_STEP;
                  end else begin
                     state_ff <= ST_FIN;
                  end
               end
            end
            ST_STEP: begin
               if ((kind_ff == rrac_pkg::MODE_CHECK && past_stop) ||
                   !match.hit || !perm_ok) begin
                  state_ff <= ST_FIN;
               end else begin
                  pos_ff  <= {1'b0, match.last} + (rrac_pkg::ADDR_BITS + 1)'(1);
                  step_ff <= step_ff + rrac_pkg::STEP_BITS'(1);
                  if (step_ff == rrac_pkg::STEP_BITS'(rrac_pkg::REGION_COUNT)) begin
                     state_ff <= ST_FIN;
                  end
               end
            end
            ST_FIN: begin
               accessible_ff <= (kind_ff == rrac_pkg::MODE_CHECK) && past_stop;
               if (kind_ff == rrac_pkg::MODE_MEASURE) begin
                  bytes_ff <= rrac_pkg::LEN_BITS'(pos_ff - {1'b0, addr_ff});
               end else begin
                  bytes_ff <= '0;
               end
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_RESP;
            end
            ST_RESP: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy            = (state_ff != ST_IDLE);
   assign pos             = pos_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_accessible  = accessible_ff;
   assign rsp_range_bytes = bytes_ff;

endmodule

// ----- rtl/region_range_access_check.sv -----
// Top level of the region range access check: port handshake and table write decode.
// Depends on rrac_pkg, rrac_table and rrac_walk.
//
// The block takes one item at a time and holds req_stall high until the result
// transfer completes. A write item, or an unused mode, passes through the finish
// state to the response state with a zero result, and its table entry is updated
// on the accepting edge. A check or measure item walks the region chain through the
// table's parallel address match, one region per cycle, for up to REGION_COUNT + 1
// (17) steps; its result is registered in the finish state after the last step.
// The next item is accepted in the cycle after the result transfer.
module region_range_access_check (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_mode,
   input  logic [rrac_pkg::INDEX_BITS-1:0]      req_region_index,
   input  logic [rrac_pkg::ADDR_BITS-1:0]       req_region_first,
   input  logic [rrac_pkg::ADDR_BITS-1:0]       req_region_last,
   input  logic [rrac_pkg::PERM_BITS-1:0]       req_region_perm,
   input  logic                                 req_region_enable,
   input  logic [rrac_pkg::ADDR_BITS-1:0]       req_query_address,
   input  logic [rrac_pkg::LEN_BITS-1:0]        req_query_length,
   input  logic [rrac_pkg::PERM_BITS-1:0]       req_required_perm,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_accessible,
   output logic [rrac_pkg::LEN_BITS-1:0]        rsp_range_bytes
);

   logic                          busy;
   logic                          accept;
   logic [rrac_pkg::ADDR_BITS:0]  pos;
   rrac_pkg::wr_type              wr;
   rrac_pkg::match_type           match;
   rrac_pkg::cmd_type             cmd;

   assign req_stall = busy;
   assign accept    = req_valid && !busy;

   always_comb begin
      wr.en    = accept && (req_mode == rrac_pkg::MODE_WRITE) &&
                 (int'(req_region_index) < rrac_pkg::REGION_COUNT);
      wr.index = req_region_index[rrac_pkg::TBL_IDX_BITS-1:0];
      wr.first = req_region_first;
      wr.last  = req_region_last;
      wr.perm  = req_region_perm;
      wr.valid = req_region_enable;

      cmd.start = accept;
      cmd.mode  = req_mode;
      cmd.addr  = req_query_address;
      cmd.len   = req_query_length;
      cmd.perm  = req_required_perm;
   end

   rrac_table u_table (
      .clock (clock),
      .reset (reset),
      .wr    (wr),
      .pos   (pos),
      .match (match)
   );

   rrac_walk u_walk (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .busy            (busy),
      .pos             (pos),
      .match           (match),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_accessible  (rsp_accessible),
      .rsp_range_bytes (rsp_range_bytes)
   );

endmodule

// ----- rtl/rrac_checker.sv -----
// Port-level checker for the region range access check, bound to the top level.
// Depends on rrac_pkg for widths and mode codes.
module rrac_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic [1:0]                           req_mode,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic                                 rsp_accessible,
   input logic [rrac_pkg::LEN_BITS-1:0]        rsp_range_bytes
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_accessible) &&
                                 $stable(rsp_range_bytes))
      else $error("result changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall && !rsp_valid)
      else $error("block not busy after an input transfer");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while a result waits");

   a_one_field: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_accessible && rsp_range_bytes != '0))
      else $error("both result fields set");

   a_write_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_mode == rrac_pkg::MODE_WRITE |->
         ##2 rsp_valid && !rsp_accessible && rsp_range_bytes == '0)
      else $error("write item result wrong or late");

endmodule

bind region_range_access_check rrac_checker u_checker (.*);
